FILE: hw/rtl/joint_command_safety_supervisor_defines.svh
// Assertion macros for the joint command safety supervisor.
// Used by the top level; needs clk and rst_n in the scope of each use.
`ifndef JOINT_COMMAND_SAFETY_SUPERVISOR_DEFINES_SVH
`define JOINT_COMMAND_SAFETY_SUPERVISOR_DEFINES_SVH
`ifndef SYNTHESIS
`define JCSS_ASSERT_CLK(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("jcss assertion failed");
`define JCSS_ASSERT(lbl, prop) `JCSS_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define JCSS_ASSERT_CLK(lbl, ck, rn, prop)
`define JCSS_ASSERT(lbl, prop)
`endif
`endif

FILE: hw/rtl/jcss_pkg.sv
// Shared types, constants and helpers of the joint command safety supervisor.
// No dependencies; used by every RTL module of the block.
package jcss_pkg;

  localparam int JOINTS  = 5;
  localparam int JOINT_W = 3;
  localparam int BEAT_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_EFFORT_LIMIT   = 3'd0,
    REG_CLAMP_HOLD     = 3'd1,
    REG_CLAMP_EV_LIMIT = 3'd2,
    REG_BIG_THRESHOLD  = 3'd3,
    REG_BIG_TICKS      = 3'd4,
    REG_SEQ_ERR_LIMIT  = 3'd5,
    REG_MISSED_TICKS   = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [14:0] RST_EFFORT_LIMIT   = 15'd1500;
  localparam logic [7:0]  RST_CLAMP_HOLD     = 8'd15;
  localparam logic [7:0]  RST_CLAMP_EV_LIMIT = 8'd3;
  localparam logic [14:0] RST_BIG_THRESHOLD  = 15'd1200;
  localparam logic [15:0] RST_BIG_TICKS      = 16'd500;
  localparam logic [7:0]  RST_SEQ_ERR_LIMIT  = 8'd5;
  localparam logic [15:0] RST_MISSED_TICKS   = 16'd100;

  // Item kinds and protocol words.
  localparam logic        KIND_FRAME  = 1'b0;
  localparam logic        KIND_TICK   = 1'b1;
  localparam logic [7:0]  RESYNC_ID   = 8'hDC;
  localparam logic [15:0] RESYNC_WORD = 16'h0BEF;
  localparam logic [15:0] LINK_REPLY  = 16'hE33E;

  // Fault flag bit positions.
  localparam int FLT_CLAMP = 0;
  localparam int FLT_SEQ   = 1;
  localparam int FLT_LINK  = 2;
  localparam int FLT_BIG   = 3;

  typedef struct packed {
    logic       kind;
    logic [7:0] joint_id;
    logic [7:0] effort_high;
    logic [7:0] effort_low;
    logic [7:0] effort_fraction;
  } item_t;

  typedef struct packed {
    logic        rel_burst;
    logic [15:0] reply;
    logic [3:0]  flags;
  } status_t;

  typedef logic [JOINTS-1:0][15:0] drive_vec_t;
  typedef logic [JOINTS-1:0][7:0]  frac_vec_t;

  // Reply word for the master: link fault wins, else the fault bits.
  function automatic logic [15:0] reply_word(input logic [3:0] flags);
    reply_word = flags[FLT_LINK] ? LINK_REPLY : {4'b0000, flags, 8'h00};
  endfunction

endpackage

FILE: hw/rtl/jcss_core.sv
// Supervisor state, configuration registers and the per-item update.
// Depends on jcss_pkg.
module jcss_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  jcss_pkg::item_t     item,
  input  logic                take,
  output jcss_pkg::status_t   status,
  output jcss_pkg::drive_vec_t rel_drive,
  output jcss_pkg::frac_vec_t  rel_frac
);

  logic [14:0] effort_limit_r;
  logic [7:0]  clamp_hold_r;
  logic [7:0]  clamp_ev_limit_r;
  logic [14:0] big_threshold_r;
  logic [15:0] big_ticks_r;
  logic [7:0]  seq_err_limit_r;
  logic [15:0] missed_limit_r;

  logic [jcss_pkg::JOINT_W-1:0] expected_r, expected_nxt;
  jcss_pkg::drive_vec_t         drive_r, drive_nxt;
  jcss_pkg::frac_vec_t          frac_r, frac_nxt;
  jcss_pkg::drive_vec_t         bigcnt_r, bigcnt_nxt;
  logic [7:0]  above_r, above_nxt;
  logic [7:0]  below_r, below_nxt;
  logic [7:0]  events_r, events_nxt;
  logic [15:0] seqerr_r, seqerr_nxt;
  logic [15:0] missed_r, missed_nxt;
  logic [3:0]  fault_r, fault_nxt;

  logic [15:0]        uw;
  logic signed [16:0] u17;
  logic signed [16:0] lim17;
  logic signed [16:0] neg_lim17;
  logic signed [16:0] ucl17;
  logic [16:0]        mag;
  logic               clamp_hi;
  logic               clamp_lo;
  logic               is_resync;
  logic               in_order;
  logic               is_last_joint;
  logic               big;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effort_limit_r   <= jcss_pkg::RST_EFFORT_LIMIT;
      clamp_hold_r     <= jcss_pkg::RST_CLAMP_HOLD;
      clamp_ev_limit_r <= jcss_pkg::RST_CLAMP_EV_LIMIT;
      big_threshold_r  <= jcss_pkg::RST_BIG_THRESHOLD;
      big_ticks_r      <= jcss_pkg::RST_BIG_TICKS;
      seq_err_limit_r  <= jcss_pkg::RST_SEQ_ERR_LIMIT;
      missed_limit_r   <= jcss_pkg::RST_MISSED_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jcss_pkg::REG_EFFORT_LIMIT:   effort_limit_r   <= cfg_wdata[14:0];
        jcss_pkg::REG_CLAMP_HOLD:     clamp_hold_r     <= cfg_wdata[7:0];
        jcss_pkg::REG_CLAMP_EV_LIMIT: clamp_ev_limit_r <= cfg_wdata[7:0];
        jcss_pkg::REG_BIG_THRESHOLD:  big_threshold_r  <= cfg_wdata[14:0];
        jcss_pkg::REG_BIG_TICKS:      big_ticks_r      <= cfg_wdata;
        jcss_pkg::REG_SEQ_ERR_LIMIT:  seq_err_limit_r  <= cfg_wdata[7:0];
        jcss_pkg::REG_MISSED_TICKS:   missed_limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame decode and effort clamp.
  always_comb begin
    uw            = {item.effort_high, item.effort_low};
    u17           = signed'({uw[15], uw});
    lim17         = signed'({2'b00, effort_limit_r});
    neg_lim17     = -lim17;
    clamp_hi      = u17 > lim17;
    clamp_lo      = u17 < neg_lim17;
    ucl17         = clamp_hi ? lim17 : (clamp_lo ? neg_lim17 : u17);
    mag           = (ucl17 < 0) ? 17'(-ucl17) : 17'(ucl17);
    is_resync     = (item.joint_id == jcss_pkg::RESYNC_ID) &&
                    (uw == jcss_pkg::RESYNC_WORD) && (item.effort_fraction == 8'h00);
    in_order      = (item.joint_id != 8'd0) &&
                    (item.joint_id <= 8'(jcss_pkg::JOINTS)) &&
                    (item.joint_id == 8'(expected_r));
    is_last_joint = expected_r == jcss_pkg::JOINT_W'(jcss_pkg::JOINTS);
  end

  // State update for the item being processed.
  always_comb begin
    expected_nxt = expected_r;
    drive_nxt    = drive_r;
    frac_nxt     = frac_r;
    bigcnt_nxt   = bigcnt_r;
    above_nxt    = above_r;
    below_nxt    = below_r;
    events_nxt   = events_r;
    seqerr_nxt   = seqerr_r;
    missed_nxt   = missed_r;
    fault_nxt    = fault_r;
    big          = 1'b0;

    if (take) begin
      if (item.kind == jcss_pkg::KIND_TICK) begin
        // Age the counters, then re-evaluate the fault flags.
        if (missed_r != 16'hFFFF) missed_nxt = missed_r + 16'd1;
        for (int i = 0; i < jcss_pkg::JOINTS; i++) begin
          if (bigcnt_r[i] != 16'hFFFF) bigcnt_nxt[i] = bigcnt_r[i] + 16'd1;
          if (bigcnt_nxt[i] >= big_ticks_r) big = 1'b1;
        end
        fault_nxt[jcss_pkg::FLT_CLAMP] = (above_r != 8'd0) || (below_r != 8'd0) ||
                                         (events_r > clamp_ev_limit_r);
        if (seqerr_r >= {8'd0, seq_err_limit_r}) begin
          fault_nxt[jcss_pkg::FLT_SEQ] = 1'b1;
        end else if (seqerr_r == 16'd0) begin
          fault_nxt[jcss_pkg::FLT_SEQ] = 1'b0;
        end
        if (missed_nxt >= missed_limit_r) fault_nxt[jcss_pkg::FLT_LINK] = 1'b1;
        fault_nxt[jcss_pkg::FLT_BIG] = big;
      end else begin
        // A resync frame clears the link fault and the stored drives.
        if (is_resync) begin
          fault_nxt[jcss_pkg::FLT_LINK] = 1'b0;
          drive_nxt = '0;
        end
        if (in_order) begin
          if (clamp_hi) begin
            above_nxt = clamp_hold_r;
            if (events_r != 8'hFF) events_nxt = events_r + 8'd1;
          end else if (clamp_lo) begin
            below_nxt = clamp_hold_r;
            if (events_r != 8'hFF) events_nxt = events_r + 8'd1;
          end else if (fault_r[jcss_pkg::FLT_CLAMP]) begin
            if (below_r != 8'd0) below_nxt = below_r - 8'd1;
            if (above_r != 8'd0) above_nxt = above_r - 8'd1;
          end
          for (int i = 0; i < jcss_pkg::JOINTS; i++) begin
            if (expected_r == jcss_pkg::JOINT_W'(i + 1)) begin
              if (mag <= {2'b00, big_threshold_r}) bigcnt_nxt[i] = '0;
              drive_nxt[i] = ucl17[15:0];
              frac_nxt[i]  = item.effort_fraction;
            end
          end
          missed_nxt = '0;
          if (seqerr_r != 16'd0) seqerr_nxt = seqerr_r - 16'd1;
          expected_nxt = is_last_joint ? jcss_pkg::JOINT_W'(1)
                                       : expected_r + jcss_pkg::JOINT_W'(1);
        end else begin
          if (seqerr_r != 16'hFFFF) seqerr_nxt = seqerr_r + 16'd1;
        end
      end
    end
  end

  // Result descriptor; drives are zeroed while any fault is set.
  always_comb begin
    status.rel_burst = (item.kind == jcss_pkg::KIND_FRAME) && in_order && is_last_joint;
    status.flags     = fault_nxt;
    status.reply     = jcss_pkg::reply_word(fault_nxt);
    for (int i = 0; i < jcss_pkg::JOINTS; i++) begin
      rel_drive[i] = (fault_r != 4'd0) ? 16'd0 : drive_nxt[i];
      rel_frac[i]  = (fault_r != 4'd0) ? 8'd0 : frac_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= jcss_pkg::JOINT_W'(1);
      drive_r    <= '0;
      frac_r     <= '0;
      bigcnt_r   <= '0;
      above_r    <= '0;
      below_r    <= '0;
      events_r   <= '0;
      seqerr_r   <= '0;
      missed_r   <= '0;
      fault_r    <= '0;
    end else begin
      expected_r <= expected_nxt;
      drive_r    <= drive_nxt;
      frac_r     <= frac_nxt;
      bigcnt_r   <= bigcnt_nxt;
      above_r    <= above_nxt;
      below_r    <= below_nxt;
      events_r   <= events_nxt;
      seqerr_r   <= seqerr_nxt;
      missed_r   <= missed_nxt;
      fault_r    <= fault_nxt;
    end
  end

endmodule

FILE: hw/rtl/jcss_out_seq.sv
// Result register and release sequencer: one status item or a burst of drives.
// Depends on jcss_pkg.
module jcss_out_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  jcss_pkg::status_t            status,
  input  jcss_pkg::drive_vec_t         rel_drive,
  input  jcss_pkg::frac_vec_t          rel_frac,
  output logic                         load_ok,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_drive_valid,
  output logic [jcss_pkg::JOINT_W-1:0] out_joint,
  output logic signed [15:0]           out_drive,
  output logic [7:0]                   out_drive_fraction,
  output logic [15:0]                  out_reply_word,
  output logic [3:0]                   out_fault_flags,
  output logic                         out_last
);

  logic                        valid_r;
  logic                        rel_r;
  logic [jcss_pkg::BEAT_W-1:0] beat_r;
  logic [15:0]                 reply_r;
  logic [3:0]                  flags_r;
  jcss_pkg::drive_vec_t        drive_r;
  jcss_pkg::frac_vec_t         frac_r;
  logic                        last;

  // The final item of a burst frees the register for the next descriptor.
  assign last    = !rel_r || (beat_r == jcss_pkg::BEAT_W'(jcss_pkg::JOINTS - 1));
  assign load_ok = !valid_r || (out_ready && last);

  // Control: valid flag and beat counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rel_r   <= 1'b0;
      beat_r  <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      rel_r   <= status.rel_burst;
      beat_r  <= '0;
    end else if (valid_r && out_ready) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        beat_r <= beat_r + jcss_pkg::BEAT_W'(1);
      end
    end
  end

  // Payload snapshot.
  always_ff @(posedge clk) begin
    if (load) begin
      reply_r <= status.reply;
      flags_r <= status.flags;
      drive_r <= rel_drive;
      frac_r  <= rel_frac;
    end
  end

  assign out_valid          = valid_r;
  assign out_drive_valid    = rel_r;
  assign out_joint          = rel_r ? jcss_pkg::JOINT_W'(beat_r) + jcss_pkg::JOINT_W'(1) : '0;
  assign out_drive          = rel_r ? signed'(drive_r[beat_r]) : 16'sd0;
  assign out_drive_fraction = rel_r ? frac_r[beat_r] : 8'd0;
  assign out_reply_word     = reply_r;
  assign out_fault_flags    = flags_r;
  assign out_last           = last;

endmodule

FILE: hw/rtl/joint_command_safety_supervisor.sv
// Joint command safety supervisor top level: input register, core, output sequencer.
// Depends on jcss_pkg, jcss_core, jcss_out_seq and the assertion macro header.
//
// Usage: the input channel (in_valid/in_ready) carries either a command frame
// (in_kind 0: joint id, effort high and low bytes, fraction) or a 1 ms tick
// (in_kind 1). Each item is registered, processed in one pass by the core,
// and its results are loaded into the output register. A tick or any frame
// other than the in-order last joint gives one status item; the in-order last
// joint frame gives one item per joint, joint 1 first, last on the final one.
// Status results are taken at one item per cycle while the receiver is ready;
// a release burst holds the output register until its last drive item is
// taken, as the single output port carries one drive per item.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes one register
// per cycle and should only be used while the block is idle.
// Reset (synchronous, rst_n low) restores the register defaults, clears all
// counters, drives and faults and expects joint 1 next; in_ready is low while
// rst_n is low. When the receiver stalls, the output holds and the input
// register fills; in_ready then drops.
`include "joint_command_safety_supervisor_defines.svh"
module joint_command_safety_supervisor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [7:0]                   in_joint_id,
  input  logic [7:0]                   in_effort_high,
  input  logic [7:0]                   in_effort_low,
  input  logic [7:0]                   in_effort_fraction,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_drive_valid,
  output logic [jcss_pkg::JOINT_W-1:0] out_joint,
  output logic signed [15:0]           out_drive,
  output logic [7:0]                   out_drive_fraction,
  output logic [15:0]                  out_reply_word,
  output logic [3:0]                   out_fault_flags,
  output logic                         out_last
);

  logic                 inv_r;
  jcss_pkg::item_t      item_r;
  logic                 load_ok;
  logic                 take;
  jcss_pkg::status_t    status;
  jcss_pkg::drive_vec_t rel_drive;
  jcss_pkg::frac_vec_t  rel_frac;

  // Input register: refills in the same cycle the held item moves on.
  assign take     = inv_r && load_ok;
  assign in_ready = rst_n && (!inv_r || load_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_ready) begin
      inv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{kind: in_kind, joint_id: in_joint_id, effort_high: in_effort_high,
                  effort_low: in_effort_low, effort_fraction: in_effort_fraction};
    end
  end

  jcss_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item_r),
    .take      (take),
    .status    (status),
    .rel_drive (rel_drive),
    .rel_frac  (rel_frac)
  );

  jcss_out_seq u_out_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (take),
    .status             (status),
    .rel_drive          (rel_drive),
    .rel_frac           (rel_frac),
    .load_ok            (load_ok),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive_valid    (out_drive_valid),
    .out_joint          (out_joint),
    .out_drive          (out_drive),
    .out_drive_fraction (out_drive_fraction),
    .out_reply_word     (out_reply_word),
    .out_fault_flags    (out_fault_flags),
    .out_last           (out_last)
  );

  // A burst item for the highest joint always closes the burst.
  `JCSS_ASSERT(a_burst_ends, (out_valid && out_drive_valid && out_joint == jcss_pkg::JOINT_W'(jcss_pkg::JOINTS)) |-> out_last)
  // A burst item taken without last is followed by the next burst item.
  `JCSS_ASSERT(a_burst_continues, (out_valid && out_ready && !out_last) |=> (out_valid && out_drive_valid))
  // Status items carry joint zero; drive items never do.
  `JCSS_ASSERT(a_joint_zero_status, out_valid |-> ((out_joint == '0) == !out_drive_valid))
  // A held item is never dropped while the output side is busy.
  `JCSS_ASSERT(a_item_held, (inv_r && !take) |=> inv_r)

endmodule
